/* rtl/rrcs_pkg.sv */
package rrcs_pkg;

    // Width of all offset and end sums: a position below 2^32 plus a 32-bit size plus a few.
    localparam int SUM_W = 34;

    localparam int LENGTH_BITS_DEFAULT = 32;

    // Bytes of the file header: RIFF, size, RMID.
    localparam int FILE_HDR_LEN = 12;

    // Four-character codes as they read little endian from the byte stream.
    localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
    localparam logic [31:0] FCC_RMID = 32'h4449_4D52;
    localparam logic [31:0] FCC_DATA = 32'h6174_6164;
    localparam logic [31:0] FCC_SFBK = 32'h6B62_6673;
    localparam logic [31:0] FCC_DLS  = 32'h2053_4C44;
    localparam logic [31:0] FCC_LIST = 32'h5453_494C;
    localparam logic [31:0] FCC_INFO = 32'h4F46_4E49;
    localparam logic [31:0] FCC_DBNK = 32'h4B4E_4244;
    localparam logic [31:0] FCC_IENC = 32'h434E_4549;
    localparam logic [31:0] FCC_MTHD = 32'h6468_544D;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_RIFF_SIZE  = 3'd2;
    localparam logic [2:0] ST_NO_DATA    = 3'd3;
    localparam logic [2:0] ST_NO_MTHD    = 3'd4;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] midi_offset;
        logic [31:0] midi_length;
        logic        bank_found;
        logic        bank_is_sf2;
        logic [31:0] bank_start;
        logic [31:0] bank_length;
        logic [6:0]  bank_number_offset;
        logic        has_text_encoding;
    } report_item_t;

endpackage

/* rtl/riff_rmid_container_scanner.sv */
// Channel   Direction  Handshake                  Item
// byte      in         byte_valid / byte_stall    byte_item (file_byte, end_of_file)
// report    out        report_valid / report_stall report_item (one per file)
// cfg       in         cfg_write                  cfg_data (bank_search_enable)
//
// One byte is taken every cycle in which byte_stall is low; the parse state for a byte is settled in that same cycle.
// The report is registered into a summary stage on the last byte and is loaded into
// report_item once that register is empty or its report is being taken.
// The next file may start while the summary stage is still waiting.
// byte_stall rises only while a finished summary and a stalled report are both waiting.
// rst_n clears the parse state asynchronously and turns the bank search on.
module riff_rmid_container_scanner
    import rrcs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic         cfg_data,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_item_t   byte_item,
    output logic         report_valid,
    input  logic         report_stall,
    output report_item_t report_item
);

    localparam int POS_W = LENGTH_BITS + 1;
    localparam logic [SUM_W-1:0] FIRST_HDR_AT = SUM_W'(FILE_HDR_LEN + 7);

    typedef enum logic [2:0] {PH_NONE, PH_DATA, PH_NEST, PH_LIST, PH_INFO} phase_t;

    typedef struct packed {
        logic [POS_W-1:0] len;
        logic             riff_ok;
        logic             rmid_ok;
        logic [32:0]      riff_end;
        logic             data_seen;
        logic             magic;
        logic [31:0]      data_start;
        logic [31:0]      data_size;
        logic [SUM_W-1:0] data_end;
        logic             bank_seen;
        logic             bank_sf2;
        logic [31:0]      bank_pos;
        logic [31:0]      bank_len;
        logic [SUM_W-1:0] bank_end;
        logic             dbnk_valid;
        logic [6:0]       dbnk_value;
        logic             enc;
    } summary_t;

    // Control state.
    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic             riff_ok_reg, riff_ok_next;
    logic             rmid_ok_reg, rmid_ok_next;
    logic [SUM_W-1:0] hdr_at_reg, hdr_at_next;
    logic             data_seen_reg, data_seen_next;
    logic             magic_reg, magic_next;
    logic             bank_seen_reg, bank_seen_next;
    logic             dbnk_valid_reg, dbnk_valid_next;
    logic             enc_reg, enc_next;
    logic             sub_is_dbnk_reg, sub_is_dbnk_next;
    logic             pend_dbnk_valid_reg, pend_dbnk_valid_next;
    logic             pend_enc_reg, pend_enc_next;
    logic             snap_valid_reg, snap_valid_next;
    logic             report_valid_reg, report_valid_next;
    logic             bank_search_en_reg;

    // Payload state.
    logic [55:0]      hist_reg, hist_next;
    logic [32:0]      riff_end_reg, riff_end_next;
    logic [SUM_W-1:0] riff_lim_reg, riff_lim_next;
    logic [SUM_W-1:0] type_at_reg, type_at_next;
    logic [31:0]      chunk_start_reg, chunk_start_next;
    logic [31:0]      chunk_size_reg, chunk_size_next;
    logic [SUM_W-1:0] chunk_end_reg, chunk_end_next;
    logic [SUM_W-1:0] list_end_reg, list_end_next;
    logic [SUM_W-1:0] sub_hdr_at_reg, sub_hdr_at_next;
    logic [SUM_W-1:0] dbnk_at_reg, dbnk_at_next;
    logic [31:0]      data_start_reg, data_start_next;
    logic [31:0]      data_size_reg, data_size_next;
    logic [SUM_W-1:0] data_end_reg, data_end_next;
    logic             bank_sf2_reg, bank_sf2_next;
    logic [31:0]      bank_pos_reg, bank_pos_next;
    logic [31:0]      bank_len_reg, bank_len_next;
    logic [SUM_W-1:0] bank_end_reg, bank_end_next;
    logic [6:0]       dbnk_value_reg, dbnk_value_next;
    logic [6:0]       pend_dbnk_reg, pend_dbnk_next;
    summary_t         snap_reg, snap_next;
    report_item_t     report_item_reg, report_item_next;

    // Per-byte working signals.
    logic             take;
    logic             last_byte;
    logic             snap_move;
    logic             consuming;
    logic [SUM_W-1:0] p34;
    logic [63:0]      window;
    logic [31:0]      low4;
    logic [31:0]      last4;
    logic [SUM_W-1:0] size34;
    logic [SUM_W-1:0] start34;
    logic [SUM_W-1:0] bank_len34;
    logic [SUM_W-1:0] sub_end34;
    logic [SUM_W-1:0] list_cur;
    logic             pad;
    logic             hdr_hit;
    logic             type_hit;
    logic             entering;
    logic             info_live;
    phase_t           phase_mid;

    // Report stage working signals.
    logic [SUM_W-1:0] len34;
    logic [2:0]       status;
    logic             bank_hit;

    assign take      = byte_valid && !byte_stall;
    assign last_byte = byte_item.end_of_file;
    assign snap_move = snap_valid_reg && (!report_valid_reg || !report_stall);
    assign byte_stall   = snap_valid_reg && report_valid_reg && report_stall;
    assign report_valid = report_valid_reg;
    assign report_item  = report_item_reg;

    // Bytes past the length limit still pass through but leave the parse untouched.
    assign consuming = !pos_reg[LENGTH_BITS];
    assign p34       = SUM_W'(pos_reg[LENGTH_BITS-1:0]);
    assign window    = {byte_item.file_byte, hist_reg};
    assign low4      = window[31:0];
    assign last4     = window[63:32];
    assign size34    = SUM_W'(last4);
    assign start34   = p34 - SUM_W'(7);
    assign bank_len34 = SUM_W'(chunk_size_reg) + SUM_W'(8);
    assign sub_end34 = p34 + SUM_W'(1) + size34;
    // A chunk ending on an odd offset carries a pad byte.
    assign pad       = ~(p34[0] ^ last4[0]);

    always_comb
    begin
        pos_next             = pos_reg;
        phase_next           = phase_reg;
        riff_ok_next         = riff_ok_reg;
        rmid_ok_next         = rmid_ok_reg;
        hdr_at_next          = hdr_at_reg;
        data_seen_next       = data_seen_reg;
        magic_next           = magic_reg;
        bank_seen_next       = bank_seen_reg;
        dbnk_valid_next      = dbnk_valid_reg;
        enc_next             = enc_reg;
        sub_is_dbnk_next     = sub_is_dbnk_reg;
        pend_dbnk_valid_next = pend_dbnk_valid_reg;
        pend_enc_next        = pend_enc_reg;
        hist_next            = hist_reg;
        riff_end_next        = riff_end_reg;
        riff_lim_next        = riff_lim_reg;
        type_at_next         = type_at_reg;
        chunk_start_next     = chunk_start_reg;
        chunk_size_next      = chunk_size_reg;
        chunk_end_next       = chunk_end_reg;
        list_end_next        = list_end_reg;
        sub_hdr_at_next      = sub_hdr_at_reg;
        dbnk_at_next         = dbnk_at_reg;
        data_start_next      = data_start_reg;
        data_size_next       = data_size_reg;
        data_end_next        = data_end_reg;
        bank_sf2_next        = bank_sf2_reg;
        bank_pos_next        = bank_pos_reg;
        bank_len_next        = bank_len_reg;
        bank_end_next        = bank_end_reg;
        dbnk_value_next      = dbnk_value_reg;
        pend_dbnk_next       = pend_dbnk_reg;
        hdr_hit              = 1'b0;
        type_hit             = 1'b0;
        entering             = 1'b0;
        info_live            = 1'b0;
        phase_mid            = phase_reg;
        list_cur             = list_end_reg;

        if (take)
        begin
            hist_next = window[63:8];
            if (consuming)
            begin
                pos_next = pos_reg + POS_W'(1);
                if (p34 < SUM_W'(FILE_HDR_LEN))
                begin
                    if (p34 == SUM_W'(3) && last4 == FCC_RIFF)
                    begin
                        riff_ok_next = 1'b1;
                    end
                    if (p34 == SUM_W'(7))
                    begin
                        riff_end_next = 33'(last4) + 33'd8;
                        // A nested chunk qualifies when its start, seven bytes back, is below
                        // the RIFF end.
                        riff_lim_next = size34 + SUM_W'(15);
                    end
                    if (p34 == SUM_W'(11) && last4 == FCC_RMID)
                    begin
                        rmid_ok_next = 1'b1;
                    end
                end
                else
                begin
                    hdr_hit  = (p34 == hdr_at_reg);
                    type_hit = !hdr_hit && (p34 == type_at_reg)
                               && (phase_reg == PH_DATA || phase_reg == PH_NEST
                                   || phase_reg == PH_LIST);
                    if (hdr_hit)
                    begin
                        chunk_start_next = start34[31:0];
                        chunk_size_next  = last4;
                        chunk_end_next   = p34 + SUM_W'(1) + size34;
                        hdr_at_next      = p34 + size34 + SUM_W'(8) + SUM_W'(pad);
                        type_at_next     = p34 + SUM_W'(4);
                        phase_mid        = PH_NONE;
                        if (low4 == FCC_DATA && !data_seen_reg)
                        begin
                            data_seen_next  = 1'b1;
                            data_start_next = p34[31:0] + 32'd1;
                            data_size_next  = last4;
                            data_end_next   = p34 + SUM_W'(1) + size34;
                            magic_next      = 1'b0;
                            if (last4 >= 32'd4)
                            begin
                                phase_mid = PH_DATA;
                            end
                        end
                        else if (low4 == FCC_RIFF && last4 >= 32'd4 && !bank_seen_reg
                                 && p34 < riff_lim_reg)
                        begin
                            phase_mid = PH_NEST;
                        end
                        else if (low4 == FCC_LIST && last4 >= 32'd4)
                        begin
                            phase_mid = PH_LIST;
                        end
                    end
                    else if (type_hit)
                    begin
                        phase_mid = PH_NONE;
                        unique case (phase_reg)
                            PH_DATA:
                            begin
                                magic_next = (last4 == FCC_MTHD);
                            end
                            PH_NEST:
                            begin
                                if (last4 == FCC_SFBK || last4 == FCC_DLS)
                                begin
                                    bank_seen_next = 1'b1;
                                    bank_sf2_next  = (last4 == FCC_SFBK);
                                    bank_pos_next  = chunk_start_reg;
                                    bank_len_next  = bank_len34[31:0];
                                    bank_end_next  = chunk_end_reg;
                                end
                            end
                            PH_LIST:
                            begin
                                if (last4 == FCC_INFO)
                                begin
                                    entering             = 1'b1;
                                    phase_mid            = PH_INFO;
                                    list_end_next        = chunk_end_reg;
                                    sub_hdr_at_next      = p34 + SUM_W'(8);
                                    sub_is_dbnk_next     = 1'b0;
                                    pend_dbnk_valid_next = 1'b0;
                                    pend_dbnk_next       = 7'd0;
                                    pend_enc_next        = 1'b0;
                                end
                            end
                            default:
                            begin
                                phase_mid = PH_NONE;
                            end
                        endcase
                    end

                    info_live = (phase_reg == PH_INFO) && !hdr_hit;
                    if (info_live)
                    begin
                        if (p34 == sub_hdr_at_reg)
                        begin
                            sub_hdr_at_next  = p34 + size34 + SUM_W'(8) + SUM_W'(pad);
                            dbnk_at_next     = p34 + SUM_W'(2);
                            sub_is_dbnk_next = 1'b0;
                            if (sub_end34 <= list_end_reg)
                            begin
                                if (low4 == FCC_DBNK && last4 == 32'd2)
                                begin
                                    sub_is_dbnk_next = 1'b1;
                                end
                                else if (low4 == FCC_IENC && last4 >= 32'd1
                                         && last4 <= 32'd31)
                                begin
                                    pend_enc_next = 1'b1;
                                end
                            end
                        end
                        else if (sub_is_dbnk_reg && p34 == dbnk_at_reg)
                        begin
                            // Two-byte little-endian value; it counts only up to 127.
                            sub_is_dbnk_next = 1'b0;
                            if (window[63:55] == 9'd0)
                            begin
                                pend_dbnk_next       = window[54:48];
                                pend_dbnk_valid_next = 1'b1;
                            end
                        end
                    end

                    // The last byte of a complete INFO list publishes what it gathered.
                    list_cur = entering ? chunk_end_reg : list_end_reg;
                    if ((entering || info_live) && (p34 + SUM_W'(1) == list_cur))
                    begin
                        dbnk_value_next = pend_dbnk_next;
                        dbnk_valid_next = pend_dbnk_valid_next;
                        enc_next        = pend_enc_next;
                        phase_mid       = PH_NONE;
                    end
                    phase_next = phase_mid;
                end
            end
        end
    end

    always_comb
    begin
        snap_next.len        = pos_next;
        snap_next.riff_ok    = riff_ok_next;
        snap_next.rmid_ok    = rmid_ok_next;
        snap_next.riff_end   = riff_end_next;
        snap_next.data_seen  = data_seen_next;
        snap_next.magic      = magic_next;
        snap_next.data_start = data_start_next;
        snap_next.data_size  = data_size_next;
        snap_next.data_end   = data_end_next;
        snap_next.bank_seen  = bank_seen_next;
        snap_next.bank_sf2   = bank_sf2_next;
        snap_next.bank_pos   = bank_pos_next;
        snap_next.bank_len   = bank_len_next;
        snap_next.bank_end   = bank_end_next;
        snap_next.dbnk_valid = dbnk_valid_next;
        snap_next.dbnk_value = dbnk_value_next;
        snap_next.enc        = enc_next;
    end

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (take && last_byte)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_move)
        begin
            snap_valid_next = 1'b0;
        end

        report_valid_next = report_valid_reg;
        if (snap_move)
        begin
            report_valid_next = 1'b1;
        end
        else if (report_valid_reg && !report_stall)
        begin
            report_valid_next = 1'b0;
        end
    end

    // Report from the captured summary of a finished file.
    always_comb
    begin
        len34            = SUM_W'(snap_reg.len);
        report_item_next = '0;
        bank_hit         = 1'b0;
        if (len34 < SUM_W'(FILE_HDR_LEN) || !snap_reg.riff_ok)
        begin
            status = ST_BAD_HEADER;
        end
        else if (SUM_W'(snap_reg.riff_end) > len34)
        begin
            status = ST_RIFF_SIZE;
        end
        else if (!snap_reg.rmid_ok)
        begin
            status = ST_BAD_HEADER;
        end
        else if (!snap_reg.data_seen || snap_reg.data_end > len34)
        begin
            status = ST_NO_DATA;
        end
        else if (snap_reg.data_size < 32'd4 || !snap_reg.magic)
        begin
            status = ST_NO_MTHD;
        end
        else
        begin
            status = ST_OK;
        end
        report_item_next.status = status;
        if (status == ST_OK)
        begin
            bank_hit = bank_search_en_reg && snap_reg.bank_seen && (snap_reg.bank_end <= len34);
            report_item_next.midi_offset = snap_reg.data_start;
            report_item_next.midi_length = snap_reg.data_size;
            report_item_next.bank_found  = bank_hit;
            if (bank_hit)
            begin
                report_item_next.bank_is_sf2 = snap_reg.bank_sf2;
                report_item_next.bank_start  = snap_reg.bank_pos;
                report_item_next.bank_length = snap_reg.bank_len;
            end
            report_item_next.bank_number_offset = snap_reg.dbnk_valid ? snap_reg.dbnk_value
                                                                      : 7'(bank_hit);
            report_item_next.has_text_encoding = snap_reg.enc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg             <= '0;
            phase_reg           <= PH_NONE;
            riff_ok_reg         <= 1'b0;
            rmid_ok_reg         <= 1'b0;
            hdr_at_reg          <= FIRST_HDR_AT;
            data_seen_reg       <= 1'b0;
            magic_reg           <= 1'b0;
            bank_seen_reg       <= 1'b0;
            dbnk_valid_reg      <= 1'b0;
            enc_reg             <= 1'b0;
            sub_is_dbnk_reg     <= 1'b0;
            pend_dbnk_valid_reg <= 1'b0;
            pend_enc_reg        <= 1'b0;
            snap_valid_reg      <= 1'b0;
            report_valid_reg    <= 1'b0;
            bank_search_en_reg  <= 1'b1;
        end
        else
        begin
            snap_valid_reg   <= snap_valid_next;
            report_valid_reg <= report_valid_next;
            if (cfg_write)
            begin
                bank_search_en_reg <= cfg_data;
            end
            if (take && last_byte)
            begin
                pos_reg             <= '0;
                phase_reg           <= PH_NONE;
                riff_ok_reg         <= 1'b0;
                rmid_ok_reg         <= 1'b0;
                hdr_at_reg          <= FIRST_HDR_AT;
                data_seen_reg       <= 1'b0;
                magic_reg           <= 1'b0;
                bank_seen_reg       <= 1'b0;
                dbnk_valid_reg      <= 1'b0;
                enc_reg             <= 1'b0;
                sub_is_dbnk_reg     <= 1'b0;
                pend_dbnk_valid_reg <= 1'b0;
                pend_enc_reg        <= 1'b0;
            end
            else
            begin
                pos_reg             <= pos_next;
                phase_reg           <= phase_next;
                riff_ok_reg         <= riff_ok_next;
                rmid_ok_reg         <= rmid_ok_next;
                hdr_at_reg          <= hdr_at_next;
                data_seen_reg       <= data_seen_next;
                magic_reg           <= magic_next;
                bank_seen_reg       <= bank_seen_next;
                dbnk_valid_reg      <= dbnk_valid_next;
                enc_reg             <= enc_next;
                sub_is_dbnk_reg     <= sub_is_dbnk_next;
                pend_dbnk_valid_reg <= pend_dbnk_valid_next;
                pend_enc_reg        <= pend_enc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg        <= hist_next;
        riff_end_reg    <= riff_end_next;
        riff_lim_reg    <= riff_lim_next;
        type_at_reg     <= type_at_next;
        chunk_start_reg <= chunk_start_next;
        chunk_size_reg  <= chunk_size_next;
        chunk_end_reg   <= chunk_end_next;
        list_end_reg    <= list_end_next;
        sub_hdr_at_reg  <= sub_hdr_at_next;
        dbnk_at_reg     <= dbnk_at_next;
        data_start_reg  <= data_start_next;
        data_size_reg   <= data_size_next;
        data_end_reg    <= data_end_next;
        bank_sf2_reg    <= bank_sf2_next;
        bank_pos_reg    <= bank_pos_next;
        bank_len_reg    <= bank_len_next;
        bank_end_reg    <= bank_end_next;
        dbnk_value_reg  <= dbnk_value_next;
        pend_dbnk_reg   <= pend_dbnk_next;
        if (take && last_byte)
        begin
            snap_reg <= snap_next;
        end
        if (snap_move)
        begin
            report_item_reg <= report_item_next;
        end
    end

    // A finished file's summary is never written over before it reaches the report register.
    a_snap_free: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_byte) |-> (!snap_valid_reg || snap_move))
        else $error("summary overwritten");

    // The position counter saturates at the length limit.
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg[LENGTH_BITS] |-> (pos_reg[LENGTH_BITS-1:0] == '0))
        else $error("position past limit");

    // A failed file reports nothing but its status.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid_reg && report_item_reg.status != ST_OK)
            |-> (report_item_reg.midi_offset == 32'd0 && !report_item_reg.bank_found
                 && report_item_reg.bank_number_offset == 7'd0))
        else $error("failure report carries data");

    // The INFO walk only runs while the file header is behind us.
    a_info_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_INFO) |-> (pos_reg >= POS_W'(FILE_HDR_LEN)))
        else $error("INFO walk inside file header");

endmodule
